FILE: rtl/bset_pkg.sv
// constants shared by the blur, sobel and threshold core
package bset_pkg;

  // default frame size limits
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // input item kinds carried on tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_REG_W  = 12;
  localparam int THR_REG_W  = 8;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [THR_REG_W-1:0] THRESH_RESET = 8'd50;

  // floor(sum/9) as (sum * 7282) >> 16, exact for sums below 32768
  localparam logic [12:0] DIV9_RECIP = 13'd7282;
  localparam int          DIV9_SHIFT = 16;

  // magnitude clamp
  localparam logic [20:0] MAG_CLAMP_SQ = 21'd65025;
  localparam logic [7:0]  MAG_MAX      = 8'd255;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

endpackage

FILE: rtl/blur_sobel_edge_threshold_core.sv
// 3x3 box blur, 3x3 sobel magnitude and threshold over a raster pixel stream
//
//  channel   | dir | handshake                         | payload
//  s_*       | in  | s_tvalid / s_tready               | s_tdata pixel, s_tuser action
//  m_*       | out | m_tvalid / m_tready               | m_tdata pixel+magnitude, m_tlast
//  apb       | in  | psel & penable & pwrite & pready  | width, height, threshold
//
// one item at a time, each walks a short sequencer: idle, raw for an item that fills only the
// raw line store, adding blur, blur2 for the blur stage and grad, sq, sqrt, done for a result;
// sqrt is bit-serial. the line stores are single memories read, modified and written back.
// reset clears counters, windows and registers; the line stores need no clearing pass.
// a result waits in the output register while the next item is accepted; a full output register
// holds the sequencer in its last state until m_tready.
module blur_sobel_edge_threshold_core #(
  parameter int MAX_WIDTH  = bset_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bset_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] pixel
  input  logic                            s_tuser,   // [0] action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [15:0]                     m_tdata,   // [7:0] edge_pixel, [15:8] edge_magnitude
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bset_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bset_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bset_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import bset_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int DW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int HDW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW   = $clog2(MAX_HEIGHT + 4);
  localparam int NW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WCMP = (DW > DIM_REG_W) ? DW : DIM_REG_W;
  localparam int HCMP = (HDW > DIM_REG_W) ? HDW : DIM_REG_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RAW, S_BLUR, S_BLUR2, S_GRAD, S_SQ, S_SQRT, S_DONE
  } state_t;

  state_t state;

  logic [DIM_REG_W-1:0] image_width;
  logic [DIM_REG_W-1:0] image_height;
  logic [THR_REG_W-1:0] edge_threshold;

  logic [CW-1:0] pcol, qcol, rcol;
  logic [RW-1:0] prow, qrow, rrow;
  logic          in_done;
  logic          drain;
  logic [7:0]    cur_val;
  logic [7:0]    cur_b;
  logic          zero_mag;
  logic [9:0]    ax, ay;
  logic [20:0]   sq_sum;
  logic [7:0]    mag;
  logic [2:0]    sbit;
  logic [NW-1:0] ocnt;
  logic [NW-1:0] nm1;
  logic [7:0]    rw [9];
  logic [7:0]    bw [9];

  logic [15:0] raw_mem  [MAX_WIDTH];
  logic [15:0] blur_mem [MAX_WIDTH];
  logic [15:0] raw_rd, blur_rd;
  logic [15:0] raw_wdata, blur_wdata;

  logic [WCMP-1:0] w_ext;
  logic [HCMP-1:0] h_ext;
  logic [DW-1:0]   eff_w;
  logic [HDW-1:0]  eff_h;
  logic [CW-1:0]   wm1;
  logic [HW-1:0]   hm1;
  logic            degenerate;

  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic        restart;
  logic        out_free;
  logic        last_out;
  logic        q_act, r_act, q_border, r_border;
  logic [7:0]  raw_top, raw_mid, blur_top, blur_mid;
  logic [11:0] win_sum;
  logic [24:0] div_prod;
  logic [9:0]  gx_pos, gx_neg, gy_pos, gy_neg;
  logic [7:0]  sq_try;
  logic [15:0] sq_try_sq;

  // effective frame size
  always_comb begin
    w_ext = WCMP'(image_width);
    h_ext = HCMP'(image_height);
    if (w_ext == '0) begin
      eff_w = DW'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      eff_w = DW'(MAX_WIDTH);
    end else begin
      eff_w = DW'(w_ext);
    end
    if (h_ext == '0) begin
      eff_h = HDW'(1);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      eff_h = HDW'(MAX_HEIGHT);
    end else begin
      eff_h = HDW'(h_ext);
    end
  end

  assign wm1        = CW'(eff_w - DW'(1));
  assign hm1        = HW'(eff_h - HDW'(1));
  assign degenerate = (eff_w < DW'(3)) || (eff_h < HDW'(3));

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_HEIGHT: prdata = CFG_DATA_W'(image_height);
      REG_THRESH: prdata = CFG_DATA_W'(edge_threshold);
      default:    prdata = '0;
    endcase
  end

  // stage activity and border tests
  assign q_act    = (prow >= RW'(2)) || ((prow == RW'(1)) && (pcol != '0));
  assign r_act    = (qrow >= RW'(2)) || ((qrow == RW'(1)) && (qcol != '0));
  assign q_border = (qrow == '0) || (qrow >= RW'(hm1)) || (qcol == '0) || (qcol >= wm1);
  assign r_border = (rrow == '0) || (rrow >= RW'(hm1)) || (rcol == '0) || (rcol >= wm1);

  // line store words hold both rows of a column, byte chosen by row parity
  assign raw_top    = prow[0] ? raw_rd[15:8] : raw_rd[7:0];
  assign raw_mid    = prow[0] ? raw_rd[7:0]  : raw_rd[15:8];
  assign raw_wdata  = prow[0] ? {cur_val, raw_rd[7:0]} : {raw_rd[15:8], cur_val};
  assign blur_top   = qrow[0] ? blur_rd[15:8] : blur_rd[7:0];
  assign blur_mid   = qrow[0] ? blur_rd[7:0]  : blur_rd[15:8];
  assign blur_wdata = qrow[0] ? {cur_b, blur_rd[7:0]} : {blur_rd[15:8], cur_b};

  always_comb begin
    win_sum = '0;
    for (int i = 0; i < 9; i++) begin
      win_sum = win_sum + 12'(rw[i]);
    end
  end

  assign div_prod = 25'(win_sum) * 25'(DIV9_RECIP);

  assign gx_pos = 10'(bw[2]) + {1'b0, bw[5], 1'b0} + 10'(bw[8]);
  assign gx_neg = 10'(bw[0]) + {1'b0, bw[3], 1'b0} + 10'(bw[6]);
  assign gy_pos = 10'(bw[6]) + {1'b0, bw[7], 1'b0} + 10'(bw[8]);
  assign gy_neg = 10'(bw[0]) + {1'b0, bw[1], 1'b0} + 10'(bw[2]);

  assign sq_try    = mag | (8'd1 << sbit);
  assign sq_try_sq = 16'(sq_try) * 16'(sq_try);

  assign out_free = !m_tvalid || m_tready;
  assign last_out = (ocnt == nm1);
  assign restart  = (cfg_we && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT)))
                 || ((state == S_DONE) && out_free && last_out);

  assign s_tready = (state == S_IDLE);

  // line stores
  always_ff @(posedge clk) begin
    raw_rd <= raw_mem[pcol];
    if (state == S_RAW) begin
      raw_mem[pcol] <= raw_wdata;
    end
  end

  always_ff @(posedge clk) begin
    blur_rd <= blur_mem[qcol];
    if (state == S_BLUR2) begin
      blur_mem[qcol] <= blur_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
      edge_threshold <= THRESH_RESET;
      pcol           <= '0;
      prow           <= '0;
      qcol           <= '0;
      qrow           <= '0;
      rcol           <= '0;
      rrow           <= '0;
      in_done        <= 1'b0;
      drain          <= 1'b0;
      ocnt           <= '0;
      nm1            <= '0;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        rw[i] <= '0;
        bw[i] <= '0;
      end
    end else begin
      nm1 <= NW'(NW'(eff_w) * NW'(eff_h)) - NW'(1);

      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WIDTH:  image_width    <= pwdata[DIM_REG_W-1:0];
          REG_HEIGHT: image_height   <= pwdata[DIM_REG_W-1:0];
          REG_THRESH: edge_threshold <= pwdata[THR_REG_W-1:0];
          default:    ;
        endcase
      end

      if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          // a flush before the frame is fully in is dropped
          if (s_tvalid && !((s_tuser == ACT_FLUSH) && !in_done)) begin
            cur_val <= in_done ? 8'd0 : s_tdata;
            drain   <= in_done;
            if (!in_done && (pcol == wm1) && (prow == RW'(hm1))) begin
              in_done <= 1'b1;
            end
            state <= S_RAW;
          end
        end
        S_RAW: begin
          for (int r = 0; r < 3; r++) begin
            rw[r*3]   <= rw[r*3+1];
            rw[r*3+1] <= rw[r*3+2];
          end
          rw[2] <= raw_top;
          rw[5] <= raw_mid;
          rw[8] <= cur_val;
          if (pcol == wm1) begin
            pcol <= '0;
            prow <= prow + RW'(1);
          end else begin
            pcol <= pcol + CW'(1);
          end
          if (q_act) begin
            state <= S_BLUR;
          end else if (drain) begin
            mag   <= '0;
            state <= S_DONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_BLUR: begin
          cur_b <= q_border ? 8'd0 : div_prod[DIV9_SHIFT +: 8];
          state <= S_BLUR2;
        end
        S_BLUR2: begin
          for (int r = 0; r < 3; r++) begin
            bw[r*3]   <= bw[r*3+1];
            bw[r*3+1] <= bw[r*3+2];
          end
          bw[2] <= blur_top;
          bw[5] <= blur_mid;
          bw[8] <= cur_b;
          if (qcol == wm1) begin
            qcol <= '0;
            qrow <= qrow + RW'(1);
          end else begin
            qcol <= qcol + CW'(1);
          end
          if (r_act) begin
            zero_mag <= r_border || degenerate;
            if (rcol == wm1) begin
              rcol <= '0;
              rrow <= rrow + RW'(1);
            end else begin
              rcol <= rcol + CW'(1);
            end
            state <= S_GRAD;
          end else if (drain) begin
            mag   <= '0;
            state <= S_DONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_GRAD: begin
          if (zero_mag) begin
            mag   <= '0;
            state <= S_DONE;
          end else begin
            ax    <= (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
            ay    <= (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          sq_sum <= 21'(20'(ax) * 20'(ax)) + 21'(20'(ay) * 20'(ay));
          mag    <= '0;
          sbit   <= 3'd7;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per cycle, msb first
          if (sq_sum >= MAG_CLAMP_SQ) begin
            mag   <= MAG_MAX;
            state <= S_DONE;
          end else begin
            if (21'(sq_try_sq) <= sq_sum) begin
              mag <= sq_try;
            end
            if (sbit == 3'd0) begin
              state <= S_DONE;
            end else begin
              sbit <= sbit - 3'd1;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {mag, (mag > edge_threshold) ? EDGE_ON : EDGE_OFF};
            m_tlast  <= last_out;
            ocnt     <= ocnt + NW'(1);
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // new frame: counters and windows start over
      if (restart) begin
        pcol    <= '0;
        prow    <= '0;
        qcol    <= '0;
        qrow    <= '0;
        rcol    <= '0;
        rrow    <= '0;
        in_done <= 1'b0;
        ocnt    <= '0;
        for (int i = 0; i < 9; i++) begin
          rw[i] <= '0;
          bw[i] <= '0;
        end
      end
    end
  end

endmodule

FILE: test/blur_sobel_edge_threshold_core_test.sv
// self-checking testbench for the blur, sobel and threshold core on its stream and apb ports
module blur_sobel_edge_threshold_core_test;
  import bset_pkg::*;

  localparam int LINE_W        = MAX_WIDTH_DEF;
  localparam int BLUR_DIVISOR  = 9;
  localparam int RAW_STAGE     = 0;
  localparam int BLUR_STAGE    = 1;
  localparam int SETTLE_CYCLES = 32;
  localparam int QUIET_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 700;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    bit [7:0] edge_px;
    bit [7:0] magnitude;
    bit       frame_end;
  } edge_res_t;

  class edge_map_predictor;
    bit [DIM_REG_W-1:0] width_reg;
    bit [DIM_REG_W-1:0] height_reg;
    bit [THR_REG_W-1:0] thresh_reg;
    bit [7:0]           lines [2][2*LINE_W];
    bit [7:0]           win [2][9];
    int unsigned        pixels_in;
    int unsigned        results_out;
    int unsigned        results_seen;
    int unsigned        errors;
    edge_res_t          edges_due [$];

    function new();
      width_reg    = WIDTH_RESET;
      height_reg   = HEIGHT_RESET;
      thresh_reg   = THRESH_RESET;
      results_seen = 0;
      errors       = 0;
      restart();
    endfunction

    function void restart();
      pixels_in   = 0;
      results_out = 0;
      foreach (win[s, i]) win[s][i] = 8'd0;
    endfunction

    function int unsigned cols();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > LINE_W) w = LINE_W;
      return w;
    endfunction

    function int unsigned rows();
      int unsigned h;
      h = height_reg;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
      return h;
    endfunction

    function int unsigned frame_size();
      return cols() * rows();
    endfunction

    function void write_reg(bit [1:0] idx, bit [31:0] value);
      unique case (idx)
        REG_WIDTH: begin
          width_reg = value[DIM_REG_W-1:0];
          restart();
        end
        REG_HEIGHT: begin
          height_reg = value[DIM_REG_W-1:0];
          restart();
        end
        REG_THRESH: thresh_reg = value[THR_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // column holds the pixels at pos-2w, pos-w and pos, the two older ones from the line store
    function void shift_column(int stage, int unsigned pos, int unsigned w, bit [7:0] val);
      int unsigned row, col, old_slot, mid_slot;
      bit [7:0] top, mid;
      int r;
      row = pos / w;
      col = pos % w;
      old_slot = (row % 2) * LINE_W + col;
      mid_slot = ((row + 1) % 2) * LINE_W + col;
      top = lines[stage][old_slot];
      mid = lines[stage][mid_slot];
      lines[stage][old_slot] = val;
      for (r = 0; r < 3; r++) begin
        win[stage][3*r]   = win[stage][3*r+1];
        win[stage][3*r+1] = win[stage][3*r+2];
      end
      win[stage][2] = top;
      win[stage][5] = mid;
      win[stage][8] = val;
    endfunction

    function bit on_ring(int unsigned pos, int unsigned w, int unsigned h);
      int unsigned x, y;
      y = pos / w;
      x = pos % w;
      return y == 0 || y + 1 >= h || x == 0 || x + 1 >= w;
    endfunction

    function bit [7:0] gradient();
      int v [9];
      int gx, gy, ax, ay;
      int unsigned sq, k;
      foreach (v[i]) v[i] = win[BLUR_STAGE][i];
      gx = -v[0] + v[2] - 2*v[3] + 2*v[5] - v[6] + v[8];
      gy = -v[0] - 2*v[1] - v[2] + v[6] + 2*v[7] + v[8];
      ax = gx < 0 ? -gx : gx;
      ay = gy < 0 ? -gy : gy;
      sq = ax*ax + ay*ay;
      if (sq >= MAG_CLAMP_SQ) return MAG_MAX;
      k = 0;
      while ((k + 1) * (k + 1) <= sq) k++;
      return k[7:0];
    endfunction

    function void advance(int unsigned pos, bit [7:0] val);
      int unsigned w, h, n, q, r, sum;
      bit [7:0] blurred, mag;
      edge_res_t res;
      w = cols();
      h = rows();
      n = w * h;
      shift_column(RAW_STAGE, pos, w, val);
      if (pos < w + 1) return;
      q = pos - w - 1;
      blurred = 8'd0;
      if (!on_ring(q, w, h)) begin
        sum = 0;
        for (int i = 0; i < 9; i++) sum += win[RAW_STAGE][i];
        blurred = 8'(sum / BLUR_DIVISOR);
      end
      shift_column(BLUR_STAGE, q, w, blurred);
      if (q < w + 1) return;
      r = q - w - 1;
      mag = on_ring(r, w, h) ? 8'd0 : gradient();
      res.edge_px   = (mag > thresh_reg) ? EDGE_ON : EDGE_OFF;
      res.magnitude = mag;
      results_out++;
      res.frame_end = (results_out >= n);
      if (res.frame_end) restart();
      edges_due.push_back(res);
    endfunction

    function void note_item(bit action, bit [7:0] pix);
      int unsigned n;
      n = frame_size();
      if (pixels_in < n) begin
        // a flush while the frame is still coming in does nothing
        if (action != ACT_PIXEL) return;
        pixels_in++;
        advance(pixels_in - 1, pix);
      end else begin
        advance(results_out + 2*cols() + 2, 8'd0);
      end
    endfunction

    function void check_result(logic [7:0] edge_px, logic [7:0] mag, logic frame_end);
      edge_res_t want;
      results_seen++;
      if (edges_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d not expected: edge %0d magnitude %0d last %0d",
                   results_seen, edge_px, mag, frame_end);
        return;
      end
      want = edges_due.pop_front();
      if (want.edge_px !== edge_px || want.magnitude !== mag || want.frame_end !== frame_end) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result %0d: expected edge %0d magnitude %0d last %0d, got %0d %0d %0d",
                   results_seen, want.edge_px, want.magnitude, want.frame_end,
                   edge_px, mag, frame_end);
      end
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = 8'd0;
  logic                  s_tuser  = ACT_PIXEL;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;
  logic                  m_tlast;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr    = '0;
  logic [CFG_DATA_W-1:0] pwdata   = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  edge_map_predictor edge_map = new();
  int source_calm = 0;
  int sink_calm   = 0;
  int sink_hold   = 0;
  int fed_items   = 0;

  blur_sobel_edge_threshold_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [31:0] with_junk(bit [31:0] v, int keep);
    return ($urandom() << keep) | v;
  endfunction

  function automatic int unsigned pick_dim(int unsigned top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(3, 8);
    if (r < 85) return $urandom_range(1, 2);
    if (r < 93) return 0;
    return $urandom_range(9, top);
  endfunction

  function automatic int unsigned pick_thresh();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 0;
    if (r < 35) return 255;
    return $urandom_range(1, 254);
  endfunction

  always @(negedge clk) begin
    if (sink_calm > 0) begin
      sink_calm--;
      sink_hold = 0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end else if ($urandom_range(0, 99) == 0) begin
      sink_calm = $urandom_range(30, 150);
    end else begin
      sink_hold = idle_len();
    end
    m_tready <= (sink_hold == 0);
  end

  always @(posedge clk) begin
    if (m_tvalid === 1'b1 && m_tready)
      edge_map.check_result(m_tdata[7:0], m_tdata[15:8], m_tlast);
  end

  task send_item(bit action, bit [7:0] pix);
    int gap;
    if (source_calm > 0) begin
      source_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) == 0) source_calm = $urandom_range(30, 120);
      gap = idle_len();
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= action;
    do @(posedge clk); while (!s_tready);
    edge_map.note_item(action, pix);
  endtask

  task apb_write(bit [1:0] idx, bit [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    edge_map.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (edge_map.edges_due.size() != 0) @(posedge clk);
  endtask

  // items that give no result may still be in the sequencer
  task settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task reconfigure(bit force_size);
    bit [2:0] pick;
    pick = 3'($urandom_range(1, 7));
    if (force_size) pick[0] = 1'b1;
    if (pick[0]) apb_write(REG_WIDTH, with_junk(pick_dim(16), DIM_REG_W));
    if (pick[1]) apb_write(REG_HEIGHT, with_junk(pick_dim(10), DIM_REG_W));
    if (pick[2]) apb_write(REG_THRESH, with_junk(pick_thresh(), THR_REG_W));
    if ($urandom_range(0, 7) == 0) apb_write(REG_SPARE, $urandom());
  endtask

  // one frame of pixels with flush noise, then the drain; abort_at >= 0 stops early
  task run_frame(int abort_at, bit bw, bit tally);
    int unsigned n, left, sent;
    bit [7:0] pix;
    n = edge_map.frame_size();
    sent = 0;
    while (edge_map.pixels_in < n && (abort_at < 0 || sent < abort_at)) begin
      if ($urandom_range(0, 11) == 0) send_item(ACT_FLUSH, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 49) == 0) wait_drained();
      if ($urandom_range(0, 99) == 0) begin
        settle();
        apb_write(REG_THRESH, with_junk(pick_thresh(), THR_REG_W));
      end
      pix = (bw && $urandom_range(0, 3) != 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                               : 8'($urandom_range(0, 255));
      send_item(ACT_PIXEL, pix);
      sent++;
    end
    if (tally) fed_items += sent;
    if (abort_at < 0) begin
      left = n - edge_map.results_out;
      // past the last pixel a pixel item is dropped but still drains one result
      repeat (left) begin
        if ($urandom_range(0, 4) == 0) send_item(ACT_PIXEL, 8'($urandom_range(0, 255)));
        else send_item(ACT_FLUSH, 8'($urandom_range(0, 255)));
      end
      if (tally) fed_items += left;
    end
  endtask

  task directed_frames();
    int i;
    apb_write(REG_SPARE, 32'hFFFF_FFFF);
    apb_write(REG_WIDTH, 4);
    apb_write(REG_HEIGHT, 3);
    apb_write(REG_THRESH, 0);
    send_item(ACT_FLUSH, 8'hFF);
    for (i = 0; i < 12; i++) send_item(ACT_PIXEL, (i % 3 == 0) ? 8'h00 : 8'hFF);
    for (i = 0; i < 10; i++) send_item((i % 2) ? ACT_PIXEL : ACT_FLUSH, 8'hFF);
    // degenerate frame, width zero taken as one
    settle();
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 5);
    apb_write(REG_THRESH, 255);
    for (i = 0; i < 5; i++) send_item(ACT_PIXEL, (i % 2) ? 8'h00 : 8'hFF);
    for (i = 0; i < 4; i++) send_item((i % 2) ? ACT_FLUSH : ACT_PIXEL, 8'h7F);
  endtask

  task extreme_frames();
    settle();
    apb_write(REG_WIDTH, with_junk(4095, DIM_REG_W));
    apb_write(REG_HEIGHT, 3);
    apb_write(REG_THRESH, 20);
    run_frame(40, 1'b1, 1'b0);
    settle();
    apb_write(REG_WIDTH, 1);
    apb_write(REG_HEIGHT, with_junk(4095, DIM_REG_W));
    run_frame(60, 1'b0, 1'b0);
    settle();
    apb_write(REG_WIDTH, 5);
    apb_write(REG_HEIGHT, 4);
  endtask

  task random_frames();
    int abort_at;
    while (fed_items < RANDOM_ITEMS) begin
      abort_at = -1;
      if ($urandom_range(0, 1)) begin
        settle();
        reconfigure(1'b0);
      end
      if ($urandom_range(0, 9) == 0) abort_at = $urandom_range(0, edge_map.frame_size() - 1);
      run_frame(abort_at, $urandom_range(0, 1), 1'b1);
      if (abort_at >= 0) begin
        settle();
        reconfigure(1'b1);
      end
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("blur_sobel_edge_threshold_core: mismatch");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_frames();
    extreme_frames();
    random_frames();
    settle();
    if (edge_map.errors == 0 && edge_map.edges_due.size() == 0) begin
      $display("blur_sobel_edge_threshold_core: match");
    end else begin
      $display("blur_sobel_edge_threshold_core: mismatch");
    end
    $finish;
  end

endmodule
